FILE: design/spp_pkg.sv
// Shared types, codes and the CRC-16 byte step for the status packet parser.
// No dependencies; imported by spp_core and status_packet_parser.
package spp_pkg;

  localparam logic [31:0] HdrWord      = 32'hFFFF_FD00;
  localparam logic [15:0] CrcPoly      = 16'h8005;
  localparam logic [15:0] TimeoutReset = 16'd5000;
  localparam logic [7:0]  NoId         = 8'hFF;
  localparam logic [15:0] MinLength    = 16'd4;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DEV_ERR = 3'd1,
    ST_CRC     = 3'd2,
    ST_BAD_HDR = 3'd3,
    ST_BAD_LEN = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_e;

  typedef enum logic {
    KIND_PARAM  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_HDR    = 4'd1,
    PH_ID     = 4'd2,
    PH_LEN_LO = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_INSTR  = 4'd5,
    PH_ERR    = 4'd6,
    PH_PARAM  = 4'd7,
    PH_CRC_LO = 4'd8,
    PH_CRC_HI = 4'd9
  } phase_e;

  typedef struct packed {
    logic        vld;
    kind_e       kind;
    logic [7:0]  param_byte;
    logic [15:0] param_index;
    logic [7:0]  node_id;
    status_e     status_code;
    logic [7:0]  device_error;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/status_packet_parser.sv
// Top level of the status packet parser: input register, parse core, result register.
// Depends on spp_pkg and spp_core.
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid_i / in_stall_o   command_i, rx_byte_i
//   out       from block out_valid_o / out_stall_i kind_o, param_byte_o, param_index_o,
//                                                  node_id_o, status_code_o, device_error_o
//   cfg       to block   cfg_we_i                  cfg_wdata_i (timeout_ticks)
//
// One word per cycle while neither channel stalls; a word is held in the input register,
// is decoded in one pass including a single CRC byte step, and its result is
// registered in the result register. Asynchronous active-low reset returns the
// parser to idle with timeout_ticks at 5000. A stalled result holds the input
// register, which then stalls the input channel.
module status_packet_parser
  import spp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  param_byte_o,
  output logic [15:0] param_index_o,
  output logic [7:0]  node_id_o,
  output logic [2:0]  status_code_o,
  output logic [7:0]  device_error_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic        in_vld_q, in_vld_d;
  logic [1:0]  cmd_q;
  logic [7:0]  byte_q;
  logic [15:0] timeout_q;
  logic        out_vld_q, out_vld_d;
  res_t        out_q;
  res_t        res;
  logic        consume;
  logic        in_take;

  assign consume    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take ? 1'b1 : (in_vld_q && !consume);
  assign out_vld_d  = (consume && res.vld) ? 1'b1 : (out_vld_q && out_stall_i);

  spp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (consume),
    .command_i       (cmd_e'(cmd_q)),
    .rx_byte_i       (byte_q),
    .timeout_ticks_i (timeout_q),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      timeout_q <= TimeoutReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
    end
    if (consume && res.vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_q.kind;
  assign param_byte_o   = out_q.param_byte;
  assign param_index_o  = out_q.param_index;
  assign node_id_o      = out_q.node_id;
  assign status_code_o  = out_q.status_code;
  assign device_error_o = out_q.device_error;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled without a held word and result");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_stall_i && !(consume && res.vld) |=> !out_vld_q)
    else $error("taken result shown again");

  a_param_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_PARAM |-> out_q.status_code == ST_OK &&
      out_q.device_error == 8'd0)
    else $error("parameter word carries status fields");

  a_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_STATUS &&
      (out_q.status_code == ST_TIMEOUT || out_q.status_code == ST_BAD_HDR)
      |-> out_q.node_id == NoId && out_q.device_error == 8'd0)
    else $error("timeout or bad header status carries an id");

endmodule

FILE: design/spp_core.sv
// Packet parsing state and per-word decode: next state and result for one word.
// Depends on spp_pkg.
module spp_core
  import spp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  cmd_e        command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] timeout_ticks_i,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [31:0] hdr_q, hdr_d;
  logic [15:0] plen_q, plen_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  err_q, err_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] timer_q, timer_d;

  logic [15:0] timer_sat;
  logic [15:0] cnt_inc;
  logic [15:0] crc_next;
  logic [31:0] hdr_next;
  logic [15:0] len_full;
  logic        in_timed;
  logic        clr;

  assign timer_sat = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;
  assign cnt_inc   = cnt_q + 16'd1;
  assign crc_next  = crc_step(crc_q, rx_byte_i);
  assign hdr_next  = {hdr_q[23:0], rx_byte_i};
  assign len_full  = {rx_byte_i, plen_q[7:0]};
  assign in_timed  = (phase_q >= PH_HDR) && (phase_q <= PH_LEN_HI);
  assign clr       = valid_i && ((command_i == CMD_START) ||
                                 (res_o.vld && res_o.kind == KIND_STATUS));

  always_comb begin
    res_o              = '0;
    res_o.kind         = KIND_PARAM;
    res_o.status_code  = ST_OK;
    if (valid_i && phase_q != PH_IDLE) begin
      case (command_i)
        CMD_TICK: begin
          if (in_timed && timer_sat >= timeout_ticks_i) begin
            res_o.vld         = 1'b1;
            res_o.kind        = KIND_STATUS;
            res_o.node_id     = NoId;
            res_o.status_code = ST_TIMEOUT;
          end
        end
        CMD_BYTE: begin
          case (phase_q)
            PH_HDR: begin
              if (cnt_q == 16'd3 && hdr_next != HdrWord) begin
                res_o.vld         = 1'b1;
                res_o.kind        = KIND_STATUS;
                res_o.node_id     = NoId;
                res_o.status_code = ST_BAD_HDR;
              end
            end
            PH_LEN_HI: begin
              if (len_full < MinLength) begin
                res_o.vld         = 1'b1;
                res_o.kind        = KIND_STATUS;
                res_o.node_id     = id_q;
                res_o.status_code = ST_BAD_LEN;
              end
            end
            PH_PARAM: begin
              if (err_q == 8'd0) begin
                res_o.vld         = 1'b1;
                res_o.param_byte  = rx_byte_i;
                res_o.param_index = cnt_q;
                res_o.node_id     = id_q;
              end
            end
            PH_CRC_HI: begin
              res_o.vld          = 1'b1;
              res_o.kind         = KIND_STATUS;
              res_o.node_id      = id_q;
              res_o.device_error = err_q;
              if (err_q != 8'd0) begin
                res_o.status_code = ST_DEV_ERR;
              end else if (crc_lo_q != crc_q[7:0] || rx_byte_i != crc_q[15:8]) begin
                res_o.status_code = ST_CRC;
              end else begin
                res_o.status_code = ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hdr_d    = hdr_q;
    plen_d   = plen_q;
    id_d     = id_q;
    err_d    = err_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    timer_d  = timer_q;
    if (valid_i && phase_q != PH_IDLE) begin
      case (command_i)
        CMD_TICK: begin
          if (in_timed) begin
            timer_d = timer_sat;
          end
        end
        CMD_BYTE: begin
          case (phase_q)
            PH_HDR: begin
              crc_d = crc_next;
              hdr_d = hdr_next;
              cnt_d = cnt_inc;
              if (cnt_q == 16'd3) begin
                cnt_d   = 16'd0;
                phase_d = PH_ID;
              end
            end
            PH_ID: begin
              crc_d   = crc_next;
              id_d    = rx_byte_i;
              phase_d = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              crc_d   = crc_next;
              plen_d  = {8'd0, rx_byte_i};
              phase_d = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              crc_d   = crc_next;
              plen_d  = len_full - MinLength;
              phase_d = PH_INSTR;
            end
            PH_INSTR: begin
              crc_d   = crc_next;
              phase_d = PH_ERR;
            end
            PH_ERR: begin
              crc_d   = crc_next;
              err_d   = rx_byte_i;
              cnt_d   = 16'd0;
              phase_d = (plen_q != 16'd0) ? PH_PARAM : PH_CRC_LO;
            end
            PH_PARAM: begin
              crc_d = crc_next;
              cnt_d = cnt_inc;
              if (cnt_inc >= plen_q) begin
                phase_d = PH_CRC_LO;
              end
            end
            PH_CRC_LO: begin
              crc_lo_d = rx_byte_i;
              phase_d  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    if (clr) begin
      phase_d  = PH_IDLE;
      cnt_d    = 16'd0;
      hdr_d    = 32'd0;
      plen_d   = 16'd0;
      id_d     = NoId;
      err_d    = 8'd0;
      crc_d    = 16'd0;
      crc_lo_d = 8'd0;
      timer_d  = 16'd0;
      if (command_i == CMD_START) begin
        phase_d = PH_HDR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= 16'd0;
      hdr_q    <= 32'd0;
      plen_q   <= 16'd0;
      id_q     <= NoId;
      err_q    <= 8'd0;
      crc_q    <= 16'd0;
      crc_lo_q <= 8'd0;
      timer_q  <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      hdr_q    <= hdr_d;
      plen_q   <= plen_d;
      id_q     <= id_d;
      err_q    <= err_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      timer_q  <= timer_d;
    end
  end

endmodule

FILE: dv/tb_status_packet_parser.sv
// Testbench for status_packet_parser: random framed packets, ticks and start commands
// are checked word by word against an in-bench parser model.
// Depends on spp_pkg and the status_packet_parser RTL.
module tb_status_packet_parser;
  import spp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdSpare   = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         NumPhases  = 7;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    bit         drain;
  } rx_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [7:0]  id;
    status_e     code;
    logic [7:0]  err;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_BYTE;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  param_byte_o;
  logic [15:0] param_index_o;
  logic [7:0]  node_id_o;
  logic [2:0]  status_code_o;
  logic [7:0]  device_error_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;

  rx_word_t      pending_words[$];
  parse_result_t expected_results[$];

  int words_queued;
  int words_sent;
  int words_taken;
  int results_taken;
  int results_noted;
  int send_gap;
  int stall_left;
  int cycle_count;
  int errors;
  int params_seen;
  int status_seen[8];
  bit no_idle;

  logic [15:0] phase_timeout[NumPhases] = '{16'hFFFF, 16'd3, 16'd0, 16'd6, 16'd1, 16'd5000, 16'd2};
  int          phase_ticks[NumPhases]   = '{30, 15, 4, 20, 6, 30, 15};

  // parser model state
  logic [15:0] timeout_limit;
  phase_e      fr_phase;
  logic [15:0] fr_count;
  logic [31:0] fr_hdr;
  logic [15:0] fr_len;
  logic [7:0]  fr_id;
  logic [7:0]  fr_err;
  logic [15:0] fr_crc;
  logic [7:0]  fr_crc_lo;
  logic [15:0] fr_ticks;
  logic        fr_open;

  status_packet_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .param_byte_o   (param_byte_o),
    .param_index_o  (param_index_o),
    .node_id_o      (node_id_o),
    .status_code_o  (status_code_o),
    .device_error_o (device_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame();
    fr_phase  = PH_IDLE;
    fr_count  = 16'h0000;
    fr_hdr    = 32'h0000_0000;
    fr_len    = 16'h0000;
    fr_id     = NoId;
    fr_err    = 8'h00;
    fr_crc    = 16'h0000;
    fr_crc_lo = 8'h00;
    fr_ticks  = 16'h0000;
    fr_open   = 1'b0;
  endfunction

  task automatic close_frame(input logic [7:0] sid, input status_e scode, input logic [7:0] serr);
    expected_results.push_back(parse_result_t'{kind: KIND_STATUS, pbyte: 8'h00, pidx: 16'h0000,
                                               id: sid, code: scode, err: serr});
    clear_frame();
  endtask

  task automatic parse_word(input logic [1:0] cmd, input logic [7:0] b);
    logic [15:0] idx;
    if (cmd == CMD_START) begin
      clear_frame();
      fr_phase = PH_HDR;
      fr_open  = 1'b1;
    end else if (fr_open && fr_phase != PH_IDLE) begin
      if (cmd == CMD_TICK) begin
        if (fr_phase >= PH_HDR && fr_phase <= PH_LEN_HI) begin
          if (fr_ticks != 16'hFFFF) begin
            fr_ticks++;
          end
          if (fr_ticks >= timeout_limit) begin
            close_frame(NoId, ST_TIMEOUT, 8'h00);
          end
        end
      end else if (cmd == CMD_BYTE) begin
        if (fr_phase != PH_CRC_LO && fr_phase != PH_CRC_HI) begin
          fr_crc = crc16_byte(fr_crc, b);
        end
        case (fr_phase)
          PH_HDR: begin
            fr_hdr = {fr_hdr[23:0], b};
            fr_count++;
            if (fr_count >= 16'd4) begin
              if (fr_hdr != HdrWord) begin
                close_frame(NoId, ST_BAD_HDR, 8'h00);
              end else begin
                fr_count = 16'h0000;
                fr_phase = PH_ID;
              end
            end
          end
          PH_ID: begin
            fr_id    = b;
            fr_phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            fr_len   = {8'h00, b};
            fr_phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            fr_len[15:8] = b;
            if (fr_len < MinLength) begin
              close_frame(fr_id, ST_BAD_LEN, 8'h00);
            end else begin
              fr_phase = PH_INSTR;
            end
          end
          PH_INSTR: begin
            fr_phase = PH_ERR;
          end
          PH_ERR: begin
            fr_err   = b;
            fr_count = 16'h0000;
            fr_phase = (fr_len > MinLength) ? PH_PARAM : PH_CRC_LO;
          end
          PH_PARAM: begin
            idx = fr_count;
            fr_count++;
            if (fr_count >= fr_len - MinLength) begin
              fr_phase = PH_CRC_LO;
            end
            if (fr_err == 8'h00) begin
              expected_results.push_back(parse_result_t'{kind: KIND_PARAM, pbyte: b, pidx: idx,
                                                         id: fr_id, code: ST_OK, err: 8'h00});
            end
          end
          PH_CRC_LO: begin
            fr_crc_lo = b;
            fr_phase  = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            if (fr_err != 8'h00) begin
              close_frame(fr_id, ST_DEV_ERR, fr_err);
            end else if ({b, fr_crc_lo} != fr_crc) begin
              close_frame(fr_id, ST_CRC, 8'h00);
            end else begin
              close_frame(fr_id, ST_OK, 8'h00);
            end
          end
          default: begin
            clear_frame();
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  task automatic check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result expected none got kind %0d byte %0h index %0d id %0h status %0d err %0h",
               $time, kind_o, param_byte_o, param_index_o, node_id_o, status_code_o,
               device_error_o);
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(kind_o));
      check_field("param_byte", 16'(want.pbyte), 16'(param_byte_o));
      check_field("param_index", want.pidx, param_index_o);
      check_field("node_id", 16'(want.id), 16'(node_id_o));
      check_field("status_code", 16'(want.code), 16'(status_code_o));
      check_field("device_error", 16'(want.err), 16'(device_error_o));
      if (want.kind == KIND_STATUS) begin
        status_seen[want.code]++;
      end else begin
        params_seen++;
      end
    end
  endtask

  // sample both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
        results_taken++;
      end
      if (in_valid_i && !in_stall_o) begin
        parse_word(command_i, rx_byte_i);
        words_taken++;
      end
    end
  end

  // word driver
  always @(negedge clk_i) begin
    rx_word_t w;
    logic     next_valid;
    next_valid = in_valid_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (words_taken == words_sent) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() > 0 &&
                   !(pending_words[0].drain && expected_results.size() > 0)) begin
        w = pending_words.pop_front();
        command_i  <= w.cmd;
        rx_byte_i  <= w.data;
        next_valid = 1'b1;
        words_sent++;
        send_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
    end
    in_valid_i <= next_valid;
  end

  // result stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (results_taken != results_noted) begin
        results_noted = results_taken;
        stall_left    = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL status_packet_parser");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] cmd, input logic [7:0] data, input bit drain);
    pending_words.push_back('{cmd, data, drain});
    words_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] pid, input logic [15:0] len, input logic [7:0] derr,
                             input bit bad_crc, input bit bad_hdr, input int cut,
                             input int tick_pct);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    int          nparam;
    int          nsend;
    int          k;
    fr.push_back(HdrWord[31:24]);
    fr.push_back(HdrWord[23:16]);
    fr.push_back(HdrWord[15:8]);
    fr.push_back(HdrWord[7:0]);
    if (bad_hdr) begin
      k     = $urandom_range(0, 3);
      fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    fr.push_back(pid);
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(derr);
    nparam = (len > MinLength) ? int'(len - MinLength) : 0;
    if (nparam > 64) begin
      nparam = 64;
    end
    repeat (nparam) fr.push_back(8'($urandom_range(0, 255)));
    crc = 16'h0000;
    foreach (fr[m]) crc = crc16_byte(crc, fr[m]);
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    nsend = fr.size();
    if (bad_hdr) begin
      nsend = 4;
    end else if (len < MinLength) begin
      nsend = 7;
    end
    if (cut >= 0 && cut < nsend) begin
      nsend = cut;
    end
    push_word(CMD_START, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    for (int j = 0; j < nsend; j++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        repeat ($urandom_range(1, 3)) push_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 49) == 0) begin
        push_word(CmdSpare, 8'($urandom_range(0, 255)), 1'b0);
      end
      push_word(CMD_BYTE, fr[j], 1'b0);
    end
  endtask

  task automatic queue_random_frame(input int tick_pct);
    logic [15:0] len;
    logic [7:0]  derr;
    int          cut;
    int          sel;
    cut = -1;
    if ($urandom_range(0, 14) == 0) begin
      cut = $urandom_range(0, 12);
    end
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      len = 16'($urandom_range(0, 3));
    end else if (sel == 1) begin
      // long frame, usually dropped partway with the next start
      len = 16'($urandom_range(16, 65535));
      cut = $urandom_range(7, 30);
    end else begin
      len = 16'($urandom_range(4, 14));
    end
    derr = 8'h00;
    if ($urandom_range(0, 3) == 0) begin
      derr = 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       push_word(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0);
          1:       push_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
          default: push_word(CmdSpare, 8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
    end
    queue_frame(8'($urandom_range(0, 255)), len, derr, $urandom_range(0, 5) == 0,
                $urandom_range(0, 14) == 0, cut, tick_pct);
  endtask

  task automatic drain_all();
    int guard;
    guard = 0;
    while ((pending_words.size() > 0 || words_taken != words_sent ||
            expected_results.size() > 0) && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    timeout_limit = v;
  endtask

  initial begin
    int target;
    timeout_limit = TimeoutReset;
    clear_frame();
    phase_timeout[NumPhases-1] = 16'($urandom_range(2, 9));
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ignored while idle
    push_word(CmdSpare, 8'h00, 1'b0);
    push_word(CMD_TICK, 8'hFF, 1'b0);
    push_word(CMD_BYTE, 8'hA5, 1'b0);
    // good frame with one parameter, bad header, length below four
    queue_frame(8'h00, 16'd5, 8'h00, 1'b0, 1'b0, -1, 0);
    queue_frame(8'h12, 16'd6, 8'h00, 1'b0, 1'b1, -1, 0);
    queue_frame(NoId, 16'd0, 8'h00, 1'b0, 1'b0, -1, 0);
    drain_all();
    // timeout on the first tick, and after one byte
    write_timeout(16'd1);
    push_word(CMD_START, 8'h00, 1'b0);
    push_word(CMD_TICK, 8'h00, 1'b0);
    push_word(CMD_START, 8'h00, 1'b0);
    push_word(CMD_BYTE, 8'hFF, 1'b0);
    push_word(CMD_TICK, 8'h00, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      drain_all();
      write_timeout(phase_timeout[p]);
      no_idle = (p == 2 || p == 5);
      target  = words_queued + 95;
      while (words_queued < target) begin
        queue_random_frame(phase_ticks[p]);
      end
      // leave the parser idle before the next register write
      queue_frame(8'($urandom_range(0, 255)), 16'($urandom_range(4, 8)), 8'h00, 1'b0, 1'b0,
                  -1, 0);
    end
    drain_all();

    if (expected_results.size() > 0) begin
      errors++;
      $display("%0t: %0d results expected but never delivered", $time, expected_results.size());
    end
    $display("Run covered %0d input words over %0d timeout settings, %0d parameter results",
             words_taken, NumPhases + 2, params_seen);
    $display("Statuses ok %0d, device error %0d, crc %0d, header %0d, length %0d, timeout %0d",
             status_seen[ST_OK], status_seen[ST_DEV_ERR], status_seen[ST_CRC],
             status_seen[ST_BAD_HDR], status_seen[ST_BAD_LEN], status_seen[ST_TIMEOUT]);
    if (errors == 0) begin
      $display("PASS status_packet_parser");
    end else begin
      $display("FAIL status_packet_parser");
    end
    $finish;
  end

endmodule
